// ----- hdl/fbcm_pkg.sv -----
package fbcm_pkg;

  localparam logic [2:0] FN_CREATE = 3'd0;
  localparam logic [2:0] FN_REMOVE = 3'd1;
  localparam logic [2:0] FN_FIRST  = 3'd2;
  localparam logic [2:0] FN_APPEND = 3'd3;
  localparam logic [2:0] FN_UNLINK = 3'd4;
  localparam logic [2:0] FN_NEXT   = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_EXISTS      = 3'd1;
  localparam logic [2:0] ST_ROOT_FULL   = 3'd2;
  localparam logic [2:0] ST_NO_FILE     = 3'd3;
  localparam logic [2:0] ST_DISK_FULL   = 3'd4;
  localparam logic [2:0] ST_NOT_IN_FILE = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT, OP_LOAD, OP_SRD, OP_SCMP, OP_DEC, OP_RD0, OP_A_CHK, OP_A_RDA,
    OP_A_POP, OP_A_CLR, OP_A_SETF, OP_W_RD, OP_AW_CHK, OP_A_LINK, OP_C_TEST, OP_C_ADV,
    OP_BLK_RD, OP_N_OUT, OP_U_SETF, OP_UW_CHK, OP_U_LWR, OP_U_FWR, OP_U_HEAD, OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic [2:0] func;
    logic       found;
    logic       f_zero;
    logic       f_hit;
    logic       tq_zero;
    logic       tq_hit;
    logic       cur_fail;
    logic       cur_hit;
    logic       steps_max;
    logic       idx_last;
    logic       init_last;
  } dp_flags_t;

endpackage

// ----- hdl/fat_block_chain_manager_unit.sv -----
// File allocation table manager: a free-list chained block table plus a root table of
// named files. One result (status, block) per request. After reset the block sweeps
// the table to its initial free-list chain, with in_stall high. Each request first
// scans the root table entry by entry; then create, remove and first block finish;
// append takes a block off the free list and walks the file's chain; next and unlink
// walk the chain through the single table memory port, unlink up to two walks. One
// request is in work at a time; the next is taken while a finished result waits in
// the output register.
module fat_block_chain_manager_unit #(
  parameter int NUM_BLOCKS   = 256,
  parameter int ROOT_ENTRIES = 16,
  parameter int TABLE_BLOCKS = 13,
  parameter int KEY_BITS     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [63:0] file_key,
  input  logic [7:0]  block_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  result_block
);

  fbcm_pkg::dp_op_t    op;
  fbcm_pkg::dp_flags_t flags;

  fbcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .op        (op)
  );

  fbcm_datapath #(
    .NUM_BLOCKS   (NUM_BLOCKS),
    .ROOT_ENTRIES (ROOT_ENTRIES),
    .TABLE_BLOCKS (TABLE_BLOCKS),
    .KEY_BITS     (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .flags      (flags),
    .func_in    (func),
    .key_in     (file_key),
    .blk_in     (block_number),
    .status_out (status),
    .result_out (result_block)
  );

`ifndef SYNTH
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= fbcm_pkg::ST_NOT_IN_FILE)
    else $error("status code out of range");

  a_error_no_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != fbcm_pkg::ST_OK |-> result_block == 8'd0)
    else $error("error result carries a block number");

  a_init_sweep: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_stall)
    else $error("input taken during table initialization");
`endif

endmodule

// ----- hdl/fbcm_ram.sv -----
module fbcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/fbcm_datapath.sv -----
module fbcm_datapath #(
  parameter int NUM_BLOCKS   = 256,
  parameter int ROOT_ENTRIES = 16,
  parameter int TABLE_BLOCKS = 13,
  parameter int KEY_BITS     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  fbcm_pkg::dp_op_t    op,
  output fbcm_pkg::dp_flags_t flags,
  input  logic [2:0]          func_in,
  input  logic [63:0]         key_in,
  input  logic [7:0]          blk_in,
  output logic [2:0]          status_out,
  output logic [7:0]          result_out
);

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int RW  = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
  localparam int SW  = $clog2(NUM_BLOCKS + 1);
  localparam int CW  = (BW > 8) ? BW : 8;
  localparam int RDW = KEY_BITS + BW;

  logic [2:0]          func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [7:0]          blk_r;
  logic [RW-1:0]       idx;
  logic [RW-1:0]       e_r;
  logic [RW-1:0]       fr_r;
  logic                found;
  logic                have_free;
  logic [BW-1:0]       first_r;
  logic [BW-1:0]       cur;
  logic [BW-1:0]       a_r;
  logic [SW-1:0]       steps;
  logic [BW-1:0]       ic;
  logic [2:0]          status_r;
  logic [BW-1:0]       result_r;
  logic [ROOT_ENTRIES-1:0] used;

  logic          t_we;
  logic [BW-1:0] t_addr;
  logic [BW-1:0] t_wd;
  logic [BW-1:0] t_q;
  logic           r_we;
  logic [RW-1:0]  r_addr;
  logic [RDW-1:0] r_wd;
  logic [RDW-1:0] r_q;

  logic [KEY_BITS-1:0] r_key;
  logic [BW-1:0]       r_first;
  logic [CW-1:0]       blk_w;
  logic [BW-1:0]       blk_addr;
  logic                steps_max;
  logic                cur_fail;

  function automatic logic [BW-1:0] rst_val(input logic [BW-1:0] i);
    int head;
    int ii;
    head = TABLE_BLOCKS + 2;
    ii   = int'(i);
    if (ii == 0) begin
      return (head < NUM_BLOCKS) ? BW'(head) : '0;
    end else if (ii == 1) begin
      return BW'(1);
    end else if (ii < head) begin
      return BW'(NUM_BLOCKS - 1);
    end else if (ii == NUM_BLOCKS - 1) begin
      return '0;
    end else begin
      return BW'(ii + 1);
    end
  endfunction

  assign r_key     = r_q[RDW-1:BW];
  assign r_first   = r_q[BW-1:0];
  assign blk_w     = CW'(blk_r);
  assign blk_addr  = BW'(blk_r);
  assign steps_max = (steps == SW'(NUM_BLOCKS));
  assign cur_fail  = (cur == '0) || steps_max;

  assign flags.func      = func_r;
  assign flags.found     = found;
  assign flags.f_zero    = (first_r == '0);
  assign flags.f_hit     = (CW'(first_r) == blk_w);
  assign flags.tq_zero   = (t_q == '0);
  assign flags.tq_hit    = (CW'(t_q) == blk_w);
  assign flags.cur_fail  = cur_fail;
  assign flags.cur_hit   = (CW'(cur) == blk_w);
  assign flags.steps_max = steps_max;
  assign flags.idx_last  = (idx == RW'(ROOT_ENTRIES - 1));
  assign flags.init_last = (ic == BW'(NUM_BLOCKS - 1));

  always_comb begin
    t_addr = '0;
    t_we   = 1'b0;
    t_wd   = '0;
    r_addr = idx;
    r_we   = 1'b0;
    r_wd   = '0;
    unique case (op)
      fbcm_pkg::OP_INIT: begin
        t_addr = ic;
        t_we   = 1'b1;
        t_wd   = rst_val(ic);
      end
      fbcm_pkg::OP_DEC: begin
        if (func_r == fbcm_pkg::FN_CREATE && !found && have_free) begin
          r_addr = fr_r;
          r_we   = 1'b1;
          r_wd   = {key_r, {BW{1'b0}}};
        end
      end
      fbcm_pkg::OP_RD0: t_addr = '0;
      fbcm_pkg::OP_A_RDA: t_addr = a_r;
      fbcm_pkg::OP_A_POP: begin
        t_addr = '0;
        t_we   = 1'b1;
        t_wd   = t_q;
      end
      fbcm_pkg::OP_A_CLR: begin
        t_addr = a_r;
        t_we   = 1'b1;
      end
      fbcm_pkg::OP_A_SETF: begin
        r_addr = e_r;
        r_we   = 1'b1;
        r_wd   = {key_r, a_r};
      end
      fbcm_pkg::OP_W_RD, fbcm_pkg::OP_C_TEST: t_addr = cur;
      fbcm_pkg::OP_A_LINK: begin
        t_addr = cur;
        t_we   = 1'b1;
        t_wd   = a_r;
      end
      fbcm_pkg::OP_BLK_RD: t_addr = blk_addr;
      fbcm_pkg::OP_U_SETF: begin
        r_addr = e_r;
        r_we   = 1'b1;
        r_wd   = {key_r, t_q};
      end
      fbcm_pkg::OP_U_LWR: begin
        t_addr = cur;
        t_we   = 1'b1;
        t_wd   = t_q;
      end
      fbcm_pkg::OP_U_FWR: begin
        t_addr = blk_addr;
        t_we   = 1'b1;
        t_wd   = t_q;
      end
      fbcm_pkg::OP_U_HEAD: begin
        t_addr = '0;
        t_we   = 1'b1;
        t_wd   = blk_addr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic   <= '0;
      used <= '0;
    end else begin
      unique case (op)
        fbcm_pkg::OP_INIT: ic <= ic + 1'b1;
        fbcm_pkg::OP_LOAD: begin
          func_r    <= func_in;
          key_r     <= key_in[KEY_BITS-1:0];
          blk_r     <= blk_in;
          idx       <= '0;
          found     <= 1'b0;
          have_free <= 1'b0;
          status_r  <= fbcm_pkg::ST_OK;
          result_r  <= '0;
        end
        fbcm_pkg::OP_SCMP: begin
          // lowest matching slot and lowest free slot win
          if (used[idx] && r_key == key_r && !found) begin
            found   <= 1'b1;
            e_r     <= idx;
            first_r <= r_first;
          end
          if (!used[idx] && !have_free) begin
            have_free <= 1'b1;
            fr_r      <= idx;
          end
          idx <= idx + 1'b1;
        end
        fbcm_pkg::OP_DEC: begin
          cur   <= first_r;
          steps <= '0;
          if (func_r == fbcm_pkg::FN_CREATE) begin
            if (found) begin
              status_r <= fbcm_pkg::ST_EXISTS;
            end else if (!have_free) begin
              status_r <= fbcm_pkg::ST_ROOT_FULL;
            end else begin
              used[fr_r] <= 1'b1;
            end
          end else if (func_r <= fbcm_pkg::FN_NEXT && !found) begin
            status_r <= fbcm_pkg::ST_NO_FILE;
          end else if (func_r == fbcm_pkg::FN_REMOVE) begin
            if (first_r == '0) begin
              used[e_r] <= 1'b0;
            end
          end else if (func_r == fbcm_pkg::FN_FIRST) begin
            result_r <= first_r;
          end
        end
        fbcm_pkg::OP_A_CHK: begin
          a_r <= t_q;
          if (t_q == '0) begin
            status_r <= fbcm_pkg::ST_DISK_FULL;
          end
        end
        fbcm_pkg::OP_A_SETF: result_r <= a_r;
        fbcm_pkg::OP_AW_CHK: begin
          if (t_q != '0 && !steps_max) begin
            cur   <= t_q;
            steps <= steps + 1'b1;
          end
        end
        fbcm_pkg::OP_A_LINK: result_r <= a_r;
        fbcm_pkg::OP_C_TEST: begin
          if (cur_fail) begin
            status_r <= fbcm_pkg::ST_NOT_IN_FILE;
          end else if (CW'(cur) == blk_w) begin
            // rewind for the unlink walk
            cur   <= first_r;
            steps <= '0;
          end
        end
        fbcm_pkg::OP_C_ADV: begin
          cur   <= t_q;
          steps <= steps + 1'b1;
        end
        fbcm_pkg::OP_N_OUT: result_r <= t_q;
        fbcm_pkg::OP_UW_CHK: begin
          if (CW'(t_q) != blk_w && !steps_max) begin
            cur   <= t_q;
            steps <= steps + 1'b1;
          end
        end
        fbcm_pkg::OP_FIN: begin
          status_out <= status_r;
          result_out <= 8'(result_r);
        end
        default: begin
        end
      endcase
    end
  end

  fbcm_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_table (
    .clk   (clk),
    .we    (t_we),
    .addr  (t_addr),
    .wdata (t_wd),
    .rdata (t_q)
  );

  fbcm_ram #(.WIDTH(RDW), .DEPTH(ROOT_ENTRIES)) u_root (
    .clk   (clk),
    .we    (r_we),
    .addr  (r_addr),
    .wdata (r_wd),
    .rdata (r_q)
  );

endmodule

// ----- hdl/fbcm_ctrl.sv -----
module fbcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  fbcm_pkg::dp_flags_t flags,
  output fbcm_pkg::dp_op_t    op
);

  typedef enum logic [27:0] {
    S_INIT   = 28'd1 << 0,  S_IDLE   = 28'd1 << 1,  S_SRD    = 28'd1 << 2,
    S_SCMP   = 28'd1 << 3,  S_DEC    = 28'd1 << 4,  S_A_RD0  = 28'd1 << 5,
    S_A_CHK  = 28'd1 << 6,  S_A_RDA  = 28'd1 << 7,  S_A_POP  = 28'd1 << 8,
    S_A_CLR  = 28'd1 << 9,  S_A_SETF = 28'd1 << 10, S_A_WRD  = 28'd1 << 11,
    S_A_WCHK = 28'd1 << 12, S_A_LINK = 28'd1 << 13, S_C_TEST = 28'd1 << 14,
    S_C_ADV  = 28'd1 << 15, S_N_RD   = 28'd1 << 16, S_N_OUT  = 28'd1 << 17,
    S_U_RDB  = 28'd1 << 18, S_U_SETF = 28'd1 << 19, S_U_WRD  = 28'd1 << 20,
    S_U_WCHK = 28'd1 << 21, S_U_LRD  = 28'd1 << 22, S_U_LWR  = 28'd1 << 23,
    S_U_FRD  = 28'd1 << 24, S_U_FWR  = 28'd1 << 25, S_U_HEAD = 28'd1 << 26,
    S_FIN    = 28'd1 << 27
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit;

  assign in_stall = (state != S_IDLE);
  assign emit     = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    op         = fbcm_pkg::OP_NONE;
    unique case (state)
      S_INIT: begin
        op = fbcm_pkg::OP_INIT;
        if (flags.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = fbcm_pkg::OP_LOAD;
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        op         = fbcm_pkg::OP_SRD;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        op         = fbcm_pkg::OP_SCMP;
        state_next = flags.idx_last ? S_DEC : S_SRD;
      end
      S_DEC: begin
        op         = fbcm_pkg::OP_DEC;
        state_next = S_FIN;
        if (flags.found && flags.func == fbcm_pkg::FN_APPEND) begin
          state_next = S_A_RD0;
        end else if (flags.found && (flags.func == fbcm_pkg::FN_UNLINK ||
                                     flags.func == fbcm_pkg::FN_NEXT)) begin
          state_next = S_C_TEST;
        end
      end
      S_A_RD0: begin
        op         = fbcm_pkg::OP_RD0;
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        op         = fbcm_pkg::OP_A_CHK;
        state_next = flags.tq_zero ? S_FIN : S_A_RDA;
      end
      S_A_RDA: begin
        op         = fbcm_pkg::OP_A_RDA;
        state_next = S_A_POP;
      end
      S_A_POP: begin
        op         = fbcm_pkg::OP_A_POP;
        state_next = S_A_CLR;
      end
      S_A_CLR: begin
        op         = fbcm_pkg::OP_A_CLR;
        state_next = flags.f_zero ? S_A_SETF : S_A_WRD;
      end
      S_A_SETF: begin
        op         = fbcm_pkg::OP_A_SETF;
        state_next = S_FIN;
      end
      S_A_WRD: begin
        op         = fbcm_pkg::OP_W_RD;
        state_next = S_A_WCHK;
      end
      S_A_WCHK: begin
        op         = fbcm_pkg::OP_AW_CHK;
        state_next = (flags.tq_zero || flags.steps_max) ? S_A_LINK : S_A_WRD;
      end
      S_A_LINK: begin
        op         = fbcm_pkg::OP_A_LINK;
        state_next = S_FIN;
      end
      S_C_TEST: begin
        op = fbcm_pkg::OP_C_TEST;
        if (flags.cur_fail) begin
          state_next = S_FIN;
        end else if (flags.cur_hit) begin
          if (flags.func == fbcm_pkg::FN_NEXT) state_next = S_N_RD;
          else if (flags.f_hit)                state_next = S_U_RDB;
          else                                 state_next = S_U_WRD;
        end else begin
          state_next = S_C_ADV;
        end
      end
      S_C_ADV: begin
        op         = fbcm_pkg::OP_C_ADV;
        state_next = S_C_TEST;
      end
      S_N_RD: begin
        op         = fbcm_pkg::OP_BLK_RD;
        state_next = S_N_OUT;
      end
      S_N_OUT: begin
        op         = fbcm_pkg::OP_N_OUT;
        state_next = S_FIN;
      end
      S_U_RDB: begin
        op         = fbcm_pkg::OP_BLK_RD;
        state_next = S_U_SETF;
      end
      S_U_SETF: begin
        op         = fbcm_pkg::OP_U_SETF;
        state_next = S_U_FRD;
      end
      S_U_WRD: begin
        op         = fbcm_pkg::OP_W_RD;
        state_next = S_U_WCHK;
      end
      S_U_WCHK: begin
        op = fbcm_pkg::OP_UW_CHK;
        if (flags.tq_hit)         state_next = S_U_LRD;
        else if (flags.steps_max) state_next = S_U_FRD;
        else                      state_next = S_U_WRD;
      end
      S_U_LRD: begin
        op         = fbcm_pkg::OP_BLK_RD;
        state_next = S_U_LWR;
      end
      S_U_LWR: begin
        op         = fbcm_pkg::OP_U_LWR;
        state_next = S_U_FRD;
      end
      S_U_FRD: begin
        op         = fbcm_pkg::OP_RD0;
        state_next = S_U_FWR;
      end
      S_U_FWR: begin
        op         = fbcm_pkg::OP_U_FWR;
        state_next = S_U_HEAD;
      end
      S_U_HEAD: begin
        op         = fbcm_pkg::OP_U_HEAD;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (emit) begin
          op         = fbcm_pkg::OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)           out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
